### rtl/pfsa_pkg.sv
// shared types, widths and codes for the page free-stack allocator
`timescale 1ns / 1ps

package pfsa_pkg;

  localparam int unsigned MAX_PAGES_DEF = 1024;
  localparam int unsigned ADDR_BITS_DEF = 32;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned FREE_W     = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned END_W      = 36;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_ALIGN = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef struct packed {
    logic    load_in;
    logic    mul;
    logic    end_calc;
    logic    rd;
    logic    div_start;
    logic    div_step;
    logic    pop;
    logic    push;
    logic    res_load;
    status_e res_code;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic alloc_ok;
    logic range_bad;
    logic rem_zero;
    logic full;
  } sts_t;

endpackage

### rtl/pfsa_ram.sv
// generic single-write, registered-read ram
`timescale 1ns / 1ps

module pfsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pfsa_ctrl.sv
// sequencer for the page allocator: handshakes, step order, output valid
`timescale 1ns / 1ps

module pfsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pfsa_pkg::sts_t sts_i,
  output pfsa_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_END,
    S_DECIDE,
    S_POP,
    S_DIV,
    S_CHECK
  } state_e;

  state_e                          state_q, state_d;
  logic [pfsa_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.res_code = pfsa_pkg::ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_END;
      end
      S_END: begin
        cmd_o.end_calc = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.mode) begin
          if (sts_i.alloc_ok) begin
            cmd_o.rd = 1'b1;
            state_d  = S_POP;
          end else if (out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = pfsa_pkg::ST_EMPTY;
            state_d        = S_IDLE;
          end
        end else if (sts_i.range_bad) begin
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = pfsa_pkg::ST_RANGE;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == pfsa_pkg::DIV_CNT_W'(pfsa_pkg::DIV_STEPS - 1)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
          if (!sts_i.rem_zero) begin
            cmd_o.res_code = pfsa_pkg::ST_ALIGN;
          end else if (sts_i.full) begin
            cmd_o.res_code = pfsa_pkg::ST_FULL;
          end else begin
            cmd_o.push     = 1'b1;
            cmd_o.res_code = pfsa_pkg::ST_OK;
          end
        end
      end
      S_POP: begin
        // ram data stays put while the output register is still occupied
        if (out_free) begin
          cmd_o.pop      = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = pfsa_pkg::ST_OK;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/pfsa_dp.sv
// datapath: settings, free stack, pool end, modulo unit and result word
`timescale 1ns / 1ps

module pfsa_dp #(
  parameter int unsigned MAX_PAGES = pfsa_pkg::MAX_PAGES_DEF,
  parameter int unsigned ADDR_BITS = pfsa_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              mode_i,
  input  logic [pfsa_pkg::ADDR_W-1:0]      page_addr_i,
  input  pfsa_pkg::cmd_t                    cmd_i,
  output pfsa_pkg::sts_t                    sts_o,
  output logic [pfsa_pkg::STATUS_W-1:0]    status_o,
  output logic [pfsa_pkg::ADDR_W-1:0]      granted_addr_o,
  output logic [pfsa_pkg::FREE_W-1:0]      free_pages_o
);

  localparam int unsigned IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  // stack entries: a bumped page may sit just above 4 GiB when the pool end is not capped there
  localparam int unsigned EW = (ADDR_BITS > 32) ? 33 : 32;
  localparam int unsigned AW = pfsa_pkg::ADDR_W;
  localparam int unsigned SW = pfsa_pkg::SIZE_W;
  localparam int unsigned NW = pfsa_pkg::END_W;
  localparam logic [NW-1:0] END_LIM = (ADDR_BITS < 35) ? (36'd1 << ADDR_BITS) : {NW{1'b1}};

  function automatic logic [CW-1:0] eff_count(input logic [pfsa_pkg::COUNT_W-1:0] c);
    logic [CW-1:0] r;
    if (32'(c) > 32'(MAX_PAGES)) begin
      r = CW'(MAX_PAGES);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  // settings and stack control
  logic [AW-1:0]                      pool_base_q, pool_base_d;
  logic [SW-1:0]                      page_size_q, page_size_d;
  logic [pfsa_pkg::COUNT_W-1:0]       page_count_q, page_count_d;
  logic [CW-1:0]                      depth_q, depth_d;
  logic [CW-1:0]                      free_q, free_d;
  logic [EW-1:0]                      bottom_q, bottom_d;

  // working word
  logic                               mode_q;
  logic [AW-1:0]                      addr_q;
  logic [2*SW-1:0]                    prod_q;
  logic [NW-1:0]                      end_q;
  logic [SW-1:0]                      rem_q, rem_d;
  logic [AW-1:0]                      dvd_q, dvd_d;
  pfsa_pkg::status_e                  status_q;
  logic [AW-1:0]                      granted_q, granted_d;
  logic [pfsa_pkg::FREE_W-1:0]        free_pages_q;

  logic                               cfg_hit;
  logic [SW-1:0]                      size_eff;
  logic [SW-1:0]                      cnt17;
  logic [NW-1:0]                      end_sum;
  logic [SW:0]                        div_t;
  logic [CW-1:0]                      pop_idx;
  logic [EW-1:0]                      ram_rdata;
  logic [EW-1:0]                      pop_addr;
  logic [EW:0]                        next_page;
  logic                               bump;

  assign size_eff = (page_size_q == '0) ? SW'(1) : page_size_q;
  assign cnt17    = SW'(eff_count(page_count_q));
  assign end_sum  = NW'(pool_base_q) + NW'(prod_q);
  assign div_t    = {rem_q, dvd_q[AW-1]};
  assign pop_idx  = depth_q - CW'(1);
  assign pop_addr = (depth_q == CW'(1)) ? bottom_q : ram_rdata;
  assign next_page = {1'b0, pop_addr} + (EW+1)'(size_eff);
  assign bump     = (pop_idx == '0) && (NW'(next_page) < end_q);

  assign cfg_hit = cfg_valid_i && ((cfg_index_i == pfsa_pkg::REG_POOL_BASE) ||
                                   (cfg_index_i == pfsa_pkg::REG_PAGE_SIZE) ||
                                   (cfg_index_i == pfsa_pkg::REG_PAGE_COUNT));

  pfsa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PAGES)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && (depth_q != '0)),
    .waddr_i (depth_q[IW-1:0]),
    .wdata_i (EW'(addr_q)),
    .re_i    (cmd_i.rd),
    .raddr_i (pop_idx[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pool_base_d  = pool_base_q;
    page_size_d  = page_size_q;
    page_count_d = page_count_q;
    depth_d      = depth_q;
    free_d       = free_q;
    bottom_d     = bottom_q;
    if (cfg_hit) begin
      case (cfg_index_i)
        pfsa_pkg::REG_POOL_BASE:  pool_base_d  = cfg_data_i[AW-1:0];
        pfsa_pkg::REG_PAGE_SIZE:  page_size_d  = cfg_data_i[SW-1:0];
        pfsa_pkg::REG_PAGE_COUNT: page_count_d = cfg_data_i[pfsa_pkg::COUNT_W-1:0];
        default: begin
          page_count_d = page_count_q;
        end
      endcase
      // any mapped register write restarts the pool
      depth_d  = CW'(1);
      free_d   = eff_count(page_count_d);
      bottom_d = EW'(pool_base_d);
    end else if (cmd_i.pop) begin
      free_d = free_q - CW'(1);
      if (bump) begin
        depth_d  = CW'(1);
        bottom_d = next_page[EW-1:0];
      end else begin
        depth_d = pop_idx;
      end
    end else if (cmd_i.push) begin
      depth_d = depth_q + CW'(1);
      free_d  = free_q + CW'(1);
      if (depth_q == '0) begin
        bottom_d = EW'(addr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      page_size_q  <= SW'(4096);
      page_count_q <= pfsa_pkg::COUNT_W'(1024);
      depth_q      <= CW'(1);
      free_q       <= eff_count(pfsa_pkg::COUNT_W'(1024));
      bottom_q     <= '0;
    end else begin
      pool_base_q  <= pool_base_d;
      page_size_q  <= page_size_d;
      page_count_q <= page_count_d;
      depth_q      <= depth_d;
      free_q       <= free_d;
      bottom_q     <= bottom_d;
    end
  end

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (cmd_i.div_start) begin
      rem_d = '0;
      dvd_d = addr_q - pool_base_q;
    end else if (cmd_i.div_step) begin
      dvd_d = dvd_q << 1;
      if (div_t >= {1'b0, size_eff}) begin
        rem_d = SW'(div_t - {1'b0, size_eff});
      end else begin
        rem_d = div_t[SW-1:0];
      end
    end
  end

  assign granted_d = cmd_i.pop ? pop_addr[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      addr_q <= page_addr_i;
    end
    if (cmd_i.mul) begin
      prod_q <= {{SW{1'b0}}, cnt17} * {{SW{1'b0}}, size_eff};
    end
    if (cmd_i.end_calc) begin
      end_q <= (end_sum > END_LIM) ? END_LIM : end_sum;
    end
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.res_load) begin
      status_q     <= cmd_i.res_code;
      granted_q    <= granted_d;
      free_pages_q <= pfsa_pkg::FREE_W'(32'(free_d));
    end
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.alloc_ok  = (depth_q != '0) && (free_q != '0);
  assign sts_o.range_bad = (addr_q < pool_base_q) || (NW'(addr_q) >= end_q);
  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.full      = (depth_q >= CW'(MAX_PAGES)) || (free_q >= CW'(MAX_PAGES));

  assign status_o       = status_q;
  assign granted_addr_o = granted_q;
  assign free_pages_o   = free_pages_q;

endmodule

### rtl/page_free_stack_allocator_core.sv
// top level of the fixed-size page allocator with a lifo free stack
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+---------------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | mode_i, page_addr_i
//  out     | out       | out_valid_o/out_ready_i | status_o, granted_addr_o, free_pages_o
//
// one request at a time: an allocate steps through the multiply, pool-end, decide and pop states; a failed
// allocate or an out-of-range release ends at the decide state, and any other release also runs the
// 32-step remainder unit for the alignment check (one dividend bit a cycle)
// reset restores the default settings and a one-entry stack at once; no clearing pass
// a new request is taken while a result waits; the last step holds until the output frees
// configuration writes are taken every cycle; a write to a mapped register restarts the pool
`timescale 1ns / 1ps

module page_free_stack_allocator_core #(
  parameter int unsigned MAX_PAGES = pfsa_pkg::MAX_PAGES_DEF,
  parameter int unsigned ADDR_BITS = pfsa_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [pfsa_pkg::ADDR_W-1:0]      page_addr_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pfsa_pkg::STATUS_W-1:0]    status_o,
  output logic [pfsa_pkg::ADDR_W-1:0]      granted_addr_o,
  output logic [pfsa_pkg::FREE_W-1:0]      free_pages_o
);

  pfsa_pkg::cmd_t cmd;
  pfsa_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  pfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfsa_dp #(
    .MAX_PAGES (MAX_PAGES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .page_addr_i    (page_addr_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .granted_addr_o (granted_addr_o),
    .free_pages_o   (free_pages_o)
  );

endmodule

### sim/pfsa_checker.sv
// result checker for the page allocator: mirrors the free stack and compares every result word
`timescale 1ns / 1ps

module pfsa_checker
  import pfsa_pkg::*;
#(
  parameter int unsigned MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  mode_i,
  input  logic [ADDR_W-1:0]     page_addr_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [ADDR_W-1:0]     granted_addr_i,
  input  logic [FREE_W-1:0]     free_pages_i,
  output int unsigned           pending_o,
  output int unsigned           fail_cnt_o
);

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   granted;
    logic [FREE_W-1:0]   free_pages;
  } reply_t;

  reply_t expected_replies[$];
  reply_t want;

  logic [ADDR_W-1:0]  cfg_base;
  logic [SIZE_W-1:0]  cfg_size;
  logic [COUNT_W-1:0] cfg_count;

  logic [ADDR_W-1:0]  stk_addr [MAX_PAGES];
  int unsigned        stk_fill;
  int unsigned        pages_left;
  int unsigned        fails;

  // a zero page size counts as one byte
  function automatic logic [63:0] step_bytes();
    return (cfg_size == '0) ? 64'd1 : {47'd0, cfg_size};
  endfunction

  function automatic logic [63:0] pages_in_pool();
    return (cfg_count > MAX_PAGES) ? 64'(MAX_PAGES) : {53'd0, cfg_count};
  endfunction

  // one past the last byte of the pool, clipped at the top of the address space
  function automatic logic [63:0] pool_limit();
    logic [63:0] lim;
    lim = {32'd0, cfg_base} + pages_in_pool() * step_bytes();
    if (lim > (64'd1 << ADDR_W)) lim = 64'd1 << ADDR_W;
    return lim;
  endfunction

  task automatic restart_pool();
    stk_addr[0] = cfg_base;
    stk_fill    = 1;
    pages_left  = 32'(pages_in_pool());
  endtask

  function automatic reply_t serve_request(logic mode, logic [ADDR_W-1:0] addr);
    reply_t      r;
    logic [63:0] sz;
    logic [63:0] lim;
    logic [63:0] a;
    logic [63:0] nxt;
    logic [63:0] ofs;
    sz        = step_bytes();
    lim       = pool_limit();
    r.status  = ST_OK;
    r.granted = '0;
    if (mode == 1'b0) begin
      if (stk_fill > 0 && pages_left > 0) begin
        stk_fill--;
        a = {32'd0, stk_addr[stk_fill % MAX_PAGES]};
        pages_left--;
        r.granted = a[ADDR_W-1:0];
        // bottom entry drained: bump to the following page if it is still in the pool
        if (stk_fill == 0) begin
          nxt = a + sz;
          if (nxt < lim) begin
            stk_addr[0] = nxt[ADDR_W-1:0];
            stk_fill    = 1;
          end
        end
      end else begin
        r.status = ST_EMPTY;
      end
    end else begin
      ofs = {32'd0, addr - cfg_base};
      if ({32'd0, addr} < {32'd0, cfg_base} || {32'd0, addr} >= lim) begin
        r.status = ST_RANGE;
      end else if (ofs % sz != 64'd0) begin
        r.status = ST_ALIGN;
      end else if (stk_fill >= MAX_PAGES || pages_left >= MAX_PAGES) begin
        r.status = ST_FULL;
      end else begin
        stk_addr[stk_fill] = addr;
        stk_fill++;
        pages_left++;
      end
    end
    r.free_pages = pages_left[FREE_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base  = '0;
      cfg_size  = SIZE_W'(4096);
      cfg_count = COUNT_W'(1024);
      restart_pool();
      expected_replies.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result word: status %0d addr %h free %0d", $time,
                   status_i, granted_addr_i, free_pages_i);
          fails++;
        end else begin
          want = expected_replies.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fails++;
          end
          if (granted_addr_i !== want.granted) begin
            $display("%0t: granted_addr expected %h actual %h", $time, want.granted,
                     granted_addr_i);
            fails++;
          end
          if (free_pages_i !== want.free_pages) begin
            $display("%0t: free_pages expected %0d actual %0d", $time, want.free_pages,
                     free_pages_i);
            fails++;
          end
        end
      end
      // any mapped register write restarts the pool; the spare index is dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_POOL_BASE: begin
            cfg_base = cfg_data_i;
            restart_pool();
          end
          REG_PAGE_SIZE: begin
            cfg_size = cfg_data_i[SIZE_W-1:0];
            restart_pool();
          end
          REG_PAGE_COUNT: begin
            cfg_count = cfg_data_i[COUNT_W-1:0];
            restart_pool();
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back(serve_request(mode_i, page_addr_i));
      end
      pending_o <= expected_replies.size();
    end
    fail_cnt_o <= fails;
  end

endmodule

### sim/tb_page_free_stack_allocator_core.sv
// testbench top for the page allocator: stimulus, output stalls and the verdict
`timescale 1ns / 1ps

module tb_page_free_stack_allocator_core;
  import pfsa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped, a write must change nothing
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 100;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  mode      = 1'b0;
  logic [ADDR_W-1:0]     page_addr = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [ADDR_W-1:0]     granted_addr;
  logic [FREE_W-1:0]     free_pages;
  int unsigned           pending;
  int unsigned           fail_cnt;
  int unsigned           cycle_cnt = 0;

  // settings as last written, used only to aim release addresses
  logic [ADDR_W-1:0]  cur_base  = '0;
  logic [SIZE_W-1:0]  cur_size  = SIZE_W'(4096);
  logic [COUNT_W-1:0] cur_count = COUNT_W'(1024);

  page_free_stack_allocator_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .page_addr_i    (page_addr),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .granted_addr_o (granted_addr),
    .free_pages_o   (free_pages)
  );

  pfsa_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .page_addr_i    (page_addr),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .granted_addr_i (granted_addr),
    .free_pages_i   (free_pages),
    .pending_o      (pending),
    .fail_cnt_o     (fail_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[page_free_stack_allocator_core] ERROR");
    $finish;
  end

  // receiver: mostly short ready stretches and short stalls, now and then a long stall or a long ready stretch
  initial begin : out_side
    int unsigned hold;
    int unsigned r;
    logic        level;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        level = 1'b1;
        hold  = $urandom_range(1, 8);
      end else if (r < 85) begin
        level = 1'b0;
        hold  = $urandom_range(1, 3);
      end else if (r < 95) begin
        level = 1'b0;
        hold  = $urandom_range(10, 60);
      end else begin
        level = 1'b1;
        hold  = $urandom_range(50, 200);
      end
      out_ready <= level;
      repeat (hold - 1) @(posedge clk);
    end
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // leaves valid high; the caller lowers it when a gap or a pause follows
  task automatic send_request(logic m, logic [ADDR_W-1:0] a);
    in_valid  <= 1'b1;
    mode      <= m;
    page_addr <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every result word has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POOL_BASE:  cur_base  = data;
      REG_PAGE_SIZE:  cur_size  = data[SIZE_W-1:0];
      REG_PAGE_COUNT: cur_count = data[COUNT_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic configure(logic [31:0] b, logic [31:0] s, logic [31:0] c);
    write_reg(REG_POOL_BASE, b);
    write_reg(REG_PAGE_SIZE, s);
    write_reg(REG_PAGE_COUNT, c);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom());
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setup();
    logic [31:0] b;
    logic [31:0] s;
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0:       b = '0;
      1:       b = 32'hFFFF_FFFF - $urandom_range(0, 32'h3_FFFF);
      default: b = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0:       s = '0;
      1:       s = 32'd1;
      2:       s = 32'h0001_FFFF;
      3:       s = 32'h0001_0000;
      4:       s = $urandom();
      default: s = $urandom_range(2, 300);
    endcase
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = 32'd1024;
      2:       c = $urandom();
      default: c = $urandom_range(1, 40);
    endcase
    configure(b, s, c);
  endtask

  // mostly aligned pages inside the pool, some misaligned, off either end or plain random
  function automatic logic [ADDR_W-1:0] pick_release_addr();
    logic [63:0] sz;
    logic [63:0] cnt;
    logic [63:0] a;
    int unsigned r;
    sz  = (cur_size == '0) ? 64'd1 : {47'd0, cur_size};
    cnt = (cur_count > 1024) ? 64'd1024 : {53'd0, cur_count};
    r   = $urandom_range(0, 99);
    a   = {32'd0, cur_base};
    if (cnt != 0) a = a + $urandom_range(0, 32'(cnt - 1)) * sz;
    if (r < 65) begin
    end else if (r < 80 && sz > 1) begin
      a = a + $urandom_range(1, 32'(sz - 1));
    end else if (r < 88) begin
      a = {32'd0, cur_base} + (cnt + $urandom_range(0, 3)) * sz;
    end else if (r < 94) begin
      a = {32'd0, cur_base} - 1 - $urandom_range(0, 255);
    end else begin
      a = {32'd0, $urandom()};
    end
    return a[ADDR_W-1:0];
  endfunction

  initial begin
    int unsigned alloc_pct;
    logic        quiet;
    logic        m;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default pool: base 0, 4 KiB pages, 1024 pages; two allocates, then releases in and out of range
    send_request(MODE_ALLOC, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 32'h0000_0000);
    send_request(MODE_RELEASE, 32'h0000_1000);
    send_request(MODE_RELEASE, 32'h0000_1001);
    send_request(MODE_RELEASE, 32'h0040_0000);
    send_request(MODE_RELEASE, 32'hFFFF_FFFF);
    send_request(MODE_RELEASE, 32'h0000_0000);
    send_request(MODE_RELEASE, 32'h003F_F000);
    drain();

    // zero page size taken as one byte, three pages: exhaustion and both range edges
    configure(32'h0001_0000, 32'h0000_0000, 32'h0000_0003);
    repeat (4) send_request(MODE_ALLOC, $urandom());
    send_request(MODE_RELEASE, 32'h0000_FFFF);
    send_request(MODE_RELEASE, 32'h0001_0003);
    send_request(MODE_RELEASE, 32'h0001_0001);
    send_request(MODE_RELEASE, 32'h0001_0002);
    drain();

    // oversized count and largest page: pool end clipped at the top of the address space
    configure(32'hFFFF_F000, 32'h0001_FFFF, 32'h0000_07FF);
    send_request(MODE_ALLOC, 32'h0000_0000);
    send_request(MODE_ALLOC, 32'hFFFF_FFFF);
    send_request(MODE_RELEASE, 32'hFFFF_FFFF);
    send_request(MODE_RELEASE, 32'hFFFF_F000);
    send_request(MODE_RELEASE, 32'hFFFF_EFFF);
    drain();

    // empty pool
    configure(32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
    send_request(MODE_ALLOC, 32'h0000_0000);
    send_request(MODE_RELEASE, 32'h0000_0000);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      random_setup();
      quiet     = ($urandom_range(0, 3) == 0);
      alloc_pct = $urandom_range(25, 75);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // spare register write mid-phase must leave the stack untouched
        if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) begin
          drain();
          write_reg(REG_SPARE, $urandom());
          cfg_valid <= 1'b0;
        end
        m = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_RELEASE;
        send_request(m, (m == MODE_ALLOC) ? $urandom() : pick_release_addr());
        if (!quiet) pause_sender(rand_gap());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[page_free_stack_allocator_core] OK");
    end else begin
      $display("[page_free_stack_allocator_core] ERROR");
    end
    $finish;
  end

endmodule
